### hw/rtl/mcpg_pkg.sv
// shared widths and opcodes of the midpoint circle pixel generator
package mcpg_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 12;
  localparam int unsigned ColourW = 8;
  localparam int unsigned PixPerStep = 8;
  localparam int unsigned PixIdxW = $clog2(PixPerStep);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

endpackage

### hw/rtl/midpoint_circle_pixel_generator.sv
// midpoint circle pixel generator with eight-way symmetry
// a step transfer loads the pending-step register, whose pixels then pass the output register
// at one pixel per cycle while out_stall_i is low; the next step is accepted as a step's last pixel advances
// a load gives no pixels; in_stall_o is high while a step's pixels remain
// reset: asynchronous, active low; clears the circle state to idle and empties both registers
module midpoint_circle_pixel_generator #(
  parameter int unsigned RADIUS_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [mcpg_pkg::CoordW-1:0]        centre_x_i,
  input  logic [mcpg_pkg::CoordW-1:0]        centre_y_i,
  input  logic [mcpg_pkg::RadiusW-1:0]       circle_radius_i,
  input  logic [mcpg_pkg::ColourW-1:0]       palette_colour_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mcpg_pkg::CoordW-1:0]        pixel_x_o,
  output logic [mcpg_pkg::CoordW-1:0]        pixel_y_o,
  output logic [mcpg_pkg::ColourW-1:0]       pixel_colour_o,
  output logic                               last_of_step_o,
  output logic                               circle_done_o
);

  localparam int unsigned R  = RADIUS_BITS;
  localparam int unsigned DW = RADIUS_BITS + 2;
  localparam int unsigned EW = RADIUS_BITS + 3;
  localparam int unsigned CW = mcpg_pkg::CoordW;
  localparam int unsigned KW = mcpg_pkg::PixIdxW;
  localparam logic [KW-1:0] KLast = KW'(mcpg_pkg::PixPerStep - 1);

  // circle state
  logic [CW-1:0]                  centre_col_q, centre_row_q;
  logic [mcpg_pkg::ColourW-1:0]   colour_q;
  logic [R-1:0]                   radius_q;
  logic signed [R:0]              oct_x_q, oct_x_d;
  logic [R-1:0]                   oct_y_q, oct_y_d;
  logic [DW-1:0]                  dx_q, dx_d, dy_q, dy_d;
  logic signed [EW-1:0]           err_q, err_d;
  logic                           active_q, active_d;

  // pending step
  logic                           job_valid_q;
  logic [CW-1:0]                  job_cx_q, job_cy_q, job_ux_q, job_uy_q;
  logic [mcpg_pkg::ColourW-1:0]   job_colour_q;
  logic                           job_done_q;
  logic [KW-1:0]                  k_q;

  // output register
  logic                           out_valid_q;
  logic [CW-1:0]                  px_q, py_q;
  logic [mcpg_pkg::ColourW-1:0]   pcol_q;
  logic                           last_q, done_q;

  logic                           in_xfer, load_go, step_go, advance, job_end;
  logic [CW-1:0]                  radius_ext;
  logic [R-1:0]                   radius_in;
  logic signed [EW-1:0]           two_r, two_r_in, err_a, err_b;
  logic [R-1:0]                   y_a;
  logic [DW-1:0]                  dy_a, dx_b;
  logic signed [R:0]              x_b;
  logic                           done_n;
  logic                           swap, neg_x, neg_y;
  logic [CW-1:0]                  ox, oy, pix_x, pix_y;

  assign advance    = job_valid_q && (!out_valid_q || !out_stall_i);
  assign job_end    = advance && (k_q == KLast);
  assign in_stall_o = job_valid_q && !job_end;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_go    = in_xfer && (opcode_i == mcpg_pkg::OP_LOAD);
  assign step_go    = in_xfer && (opcode_i == mcpg_pkg::OP_STEP) && active_q;

  assign radius_ext = CW'(circle_radius_i);
  assign radius_in  = radius_ext[R-1:0];
  assign two_r_in   = $signed({2'b00, radius_in, 1'b0});
  assign two_r      = $signed({2'b00, radius_q, 1'b0});

  // octant update
  always_comb begin
    if (err_q <= 0) begin
      err_a = err_q + $signed({1'b0, dy_q});
      y_a   = oct_y_q + R'(1);
      dy_a  = dy_q + DW'(2);
    end else begin
      err_a = err_q;
      y_a   = oct_y_q;
      dy_a  = dy_q;
    end
    if (err_a > 0) begin
      x_b   = oct_x_q - (R+1)'(1);
      dx_b  = dx_q + DW'(2);
      err_b = err_a + $signed({1'b0, dx_b}) - two_r;
    end else begin
      x_b   = oct_x_q;
      dx_b  = dx_q;
      err_b = err_a;
    end
    done_n = x_b < $signed({1'b0, y_a});
  end

  always_comb begin
    oct_x_d  = oct_x_q;
    oct_y_d  = oct_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    err_d    = err_q;
    active_d = active_q;
    if (load_go) begin
      oct_x_d  = $signed({1'b0, radius_in}) - (R+1)'(1);
      oct_y_d  = '0;
      dx_d     = DW'(1);
      dy_d     = DW'(1);
      err_d    = EW'(1) - two_r_in;
      active_d = (radius_in != '0);
    end else if (step_go) begin
      oct_x_d  = x_b;
      oct_y_d  = y_a;
      dx_d     = dx_b;
      dy_d     = dy_a;
      err_d    = err_b;
      active_d = !done_n;
    end
  end

  // mirror selection for pixel k
  assign swap  = k_q[0] ^ k_q[1];
  assign neg_x = k_q[1] ^ k_q[2];
  assign neg_y = k_q[2];
  assign ox    = swap ? job_uy_q : job_ux_q;
  assign oy    = swap ? job_ux_q : job_uy_q;
  assign pix_x = neg_x ? (job_cx_q - ox) : (job_cx_q + ox);
  assign pix_y = neg_y ? (job_cy_q - oy) : (job_cy_q + oy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_col_q <= '0;
      centre_row_q <= '0;
      colour_q     <= '0;
      radius_q     <= '0;
      oct_x_q      <= '0;
      oct_y_q      <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      err_q        <= '0;
      active_q     <= 1'b0;
      job_valid_q  <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      oct_x_q  <= oct_x_d;
      oct_y_q  <= oct_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      err_q    <= err_d;
      active_q <= active_d;
      if (load_go) begin
        centre_col_q <= centre_x_i;
        centre_row_q <= centre_y_i;
        colour_q     <= palette_colour_i;
        radius_q     <= radius_in;
      end
      if (step_go) begin
        job_valid_q <= 1'b1;
        k_q         <= '0;
      end else if (job_end) begin
        job_valid_q <= 1'b0;
      end else if (advance) begin
        k_q <= k_q + KW'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      job_cx_q     <= centre_col_q;
      job_cy_q     <= centre_row_q;
      job_ux_q     <= CW'(oct_x_q[R-1:0]);
      job_uy_q     <= CW'(oct_y_q);
      job_colour_q <= colour_q;
      job_done_q   <= done_n;
    end
    if (advance) begin
      px_q   <= pix_x;
      py_q   <= pix_y;
      pcol_q <= job_colour_q;
      last_q <= (k_q == KLast);
      done_q <= (k_q == KLast) && job_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_colour_o = pcol_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

### hw/rtl/mcpg_checker.sv
// port checks for the midpoint circle pixel generator, bound to the top level
module mcpg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mcpg_pkg::CoordW-1:0]  pixel_x_o,
  input logic [mcpg_pkg::CoordW-1:0]  pixel_y_o,
  input logic                         last_of_step_o,
  input logic                         circle_done_o
);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o))
    else $error("stalled pixel changed");

  // circle end only on the closing pixel of a step
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> last_of_step_o)
    else $error("circle_done_o without last_of_step_o");

  // pixels of one step follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_step_o |=> out_valid_o)
    else $error("gap inside a step");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("pixel valid during reset");

endmodule

bind midpoint_circle_pixel_generator mcpg_checker u_mcpg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_x_o      (pixel_x_o),
  .pixel_y_o      (pixel_y_o),
  .last_of_step_o (last_of_step_o),
  .circle_done_o  (circle_done_o)
);

### verif/tb_midpoint_circle_pixel_generator.sv
// self-checking testbench of the midpoint circle pixel generator
`timescale 1ns / 1ps

module tb_midpoint_circle_pixel_generator;

  localparam int unsigned NumRandom = 350;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned NumDirRows = 25;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_DOT
  } chk_e;

  typedef struct packed {
    mcpg_pkg::op_e                op;
    logic [mcpg_pkg::CoordW-1:0]  cx;
    logic [mcpg_pkg::CoordW-1:0]  cy;
    logic [mcpg_pkg::RadiusW-1:0] rad;
    logic [mcpg_pkg::ColourW-1:0] col;
    chk_e                         chk;
  } stim_row_t;

  typedef struct packed {
    logic [mcpg_pkg::CoordW-1:0]  x;
    logic [mcpg_pkg::CoordW-1:0]  y;
    logic [mcpg_pkg::ColourW-1:0] col;
    logic                         last;
    logic                         done;
  } pixel_t;

  // a dot row expects eight pixels at its own cx, cy and col, done on the eighth
  localparam stim_row_t DirRows [NumDirRows] = '{
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_NONE},
    '{mcpg_pkg::OP_LOAD, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF, CHK_NONE},
    '{mcpg_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 12'h001, 8'hFF, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'hFFFF, 16'hFFFF, 12'h000, 8'hFF, CHK_DOT},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_NONE},
    '{mcpg_pkg::OP_LOAD, 16'h0000, 16'h0000, 12'h005, 8'hA5, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'h5555, 16'hAAAA, 12'h555, 8'h55, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'hAAAA, 16'h5555, 12'hAAA, 8'hAA, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_LOAD, 16'h1234, 16'hABCD, 12'hFFF, 8'h5A, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'hFFFF, 16'h0000, 12'hFFF, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'hFFFF, 12'h000, 8'hFF, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_LOAD, 16'h8000, 16'h7FFF, 12'h002, 8'h3C, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_LOAD, 16'h0001, 16'hFFFE, 12'h003, 8'hC3, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'h0000, 12'h000, 8'h00, CHK_MODEL},
    '{mcpg_pkg::OP_LOAD, 16'h0000, 16'hFFFF, 12'h001, 8'h00, CHK_NONE},
    '{mcpg_pkg::OP_STEP, 16'h0000, 16'hFFFF, 12'h000, 8'h00, CHK_DOT}
  };

  logic                         clk;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         opcode_i = 1'b0;
  logic [mcpg_pkg::CoordW-1:0]  centre_x_i = '0;
  logic [mcpg_pkg::CoordW-1:0]  centre_y_i = '0;
  logic [mcpg_pkg::RadiusW-1:0] circle_radius_i = '0;
  logic [mcpg_pkg::ColourW-1:0] palette_colour_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [mcpg_pkg::CoordW-1:0]  pixel_x_o;
  logic [mcpg_pkg::CoordW-1:0]  pixel_y_o;
  logic [mcpg_pkg::ColourW-1:0] pixel_colour_o;
  logic                         last_of_step_o;
  logic                         circle_done_o;

  logic                         calm = 1'b0;
  int unsigned                  err_cnt = 0;
  int unsigned                  idle_cycles = 0;

  pixel_t                       pix_expected [$];
  pixel_t                       step_pixels [$];

  logic [mcpg_pkg::CoordW-1:0]  circ_cx;
  logic [mcpg_pkg::CoordW-1:0]  circ_cy;
  logic [mcpg_pkg::RadiusW-1:0] circ_rad;
  logic [mcpg_pkg::ColourW-1:0] circ_col;
  logic signed [12:0]           oct_x;
  logic [11:0]                  oct_y;
  logic [13:0]                  inc_x;
  logic [13:0]                  inc_y;
  logic signed [15:0]           dec_err;
  logic                         circ_on;

  midpoint_circle_pixel_generator dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .centre_x_i       (centre_x_i),
    .centre_y_i       (centre_y_i),
    .circle_radius_i  (circle_radius_i),
    .palette_colour_i (palette_colour_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .pixel_colour_o   (pixel_colour_o),
    .last_of_step_o   (last_of_step_o),
    .circle_done_o    (circle_done_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (err_cnt < 100) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  function automatic pixel_t mk_pix(logic [mcpg_pkg::CoordW-1:0] x,
                                    logic [mcpg_pkg::CoordW-1:0] y,
                                    logic last, logic done);
    pixel_t p;
    p.x    = x;
    p.y    = y;
    p.col  = circ_col;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  task automatic predict_circle(input stim_row_t row);
    logic [mcpg_pkg::CoordW-1:0] ux;
    logic [mcpg_pkg::CoordW-1:0] uy;
    logic                        fin;
    step_pixels.delete();
    if (row.op == mcpg_pkg::OP_LOAD) begin
      circ_cx  = row.cx;
      circ_cy  = row.cy;
      circ_rad = row.rad;
      circ_col = row.col;
      oct_x    = $signed({1'b0, row.rad}) - 13'sd1;
      oct_y    = '0;
      inc_x    = 14'd1;
      inc_y    = 14'd1;
      dec_err  = 16'(1 - 2 * int'(row.rad));
      circ_on  = (row.rad != '0);
    end else if (!circ_on || int'(oct_x) < int'(oct_y)) begin
      circ_on = 1'b0;
    end else begin
      ux = 16'(oct_x);
      uy = 16'(oct_y);
      if (dec_err <= 16'sd0) begin
        oct_y   = oct_y + 12'd1;
        dec_err = dec_err + 16'(inc_y);
        inc_y   = inc_y + 14'd2;
      end
      if (dec_err > 16'sd0) begin
        oct_x   = oct_x - 13'sd1;
        inc_x   = inc_x + 14'd2;
        dec_err = dec_err + 16'(inc_x) - 16'({circ_rad, 1'b0});
      end
      fin = int'(oct_x) < int'(oct_y);
      if (fin) begin
        circ_on = 1'b0;
      end
      step_pixels.push_back(mk_pix(circ_cx + ux, circ_cy + uy, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx + uy, circ_cy + ux, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx - uy, circ_cy + ux, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx - ux, circ_cy + uy, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx - ux, circ_cy - uy, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx - uy, circ_cy - ux, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx + uy, circ_cy - ux, 1'b0, 1'b0));
      step_pixels.push_back(mk_pix(circ_cx + ux, circ_cy - uy, 1'b1, fin));
    end
  endtask

  task automatic send_item(input stim_row_t row);
    int unsigned gap;
    pixel_t      dot;
    gap = calm ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid_i = 1'b0;
    end
    @(negedge clk);
    in_valid_i       = 1'b1;
    opcode_i         = row.op;
    centre_x_i       = row.cx;
    centre_y_i       = row.cy;
    circle_radius_i  = row.rad;
    palette_colour_i = row.col;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predict_circle(row);
    case (row.chk)
      CHK_MODEL: begin
        foreach (step_pixels[i]) pix_expected.push_back(step_pixels[i]);
      end
      CHK_DOT: begin
        dot.x   = row.cx;
        dot.y   = row.cy;
        dot.col = row.col;
        for (int i = 0; i < mcpg_pkg::PixPerStep; i++) begin
          dot.last = (i == mcpg_pkg::PixPerStep - 1);
          dot.done = dot.last;
          pix_expected.push_back(dot);
        end
      end
      default: begin
      end
    endcase
  endtask

  // receiver: random stall before each transfer
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 15);
      repeat (hold) begin
        @(negedge clk);
        out_stall_i = 1'b1;
      end
      @(negedge clk);
      out_stall_i = 1'b0;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{x: pixel_x_o, y: pixel_y_o, col: pixel_colour_o,
              last: last_of_step_o, done: circle_done_o};
      if (pix_expected.size() == 0) begin
        report_error($sformatf("unexpected pixel x=%h y=%h col=%h last=%b done=%b",
                               got.x, got.y, got.col, got.last, got.done));
      end else begin
        want = pix_expected.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.col !== want.col ||
            got.last !== want.last || got.done !== want.done) begin
          report_error($sformatf("got x=%h y=%h col=%h last=%b done=%b, want %h %h %h %b %b",
                                 got.x, got.y, got.col, got.last, got.done,
                                 want.x, want.y, want.col, want.last, want.done));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t   row;
    int unsigned n_items;
    int unsigned iter;
    int unsigned since_load;
    int unsigned abandon_at;
    int unsigned pick;
    n_items    = 0;
    iter       = 0;
    since_load = 0;
    abandon_at = 0;
    circ_on    = 1'b0;
    circ_cx    = '0;
    circ_cy    = '0;
    circ_rad   = '0;
    circ_col   = '0;
    oct_x      = '0;
    oct_y      = '0;
    inc_x      = '0;
    inc_y      = '0;
    dec_err    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (DirRows[i]) send_item(DirRows[i]);

    while (n_items < NumRandom) begin
      if (iter % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      iter++;
      row.cx  = 16'($urandom);
      row.cy  = 16'($urandom);
      row.rad = 12'($urandom);
      row.col = 8'($urandom);
      row.chk = CHK_MODEL;
      if (circ_on && since_load < abandon_at && $urandom_range(0, 99) < 95) begin
        row.op = mcpg_pkg::OP_STEP;
      end else if (!circ_on && $urandom_range(0, 99) < 15) begin
        row.op = mcpg_pkg::OP_STEP;
      end else begin
        row.op = mcpg_pkg::OP_LOAD;
        pick   = $urandom_range(0, 99);
        if (pick < 6) begin
          row.rad    = '0;
          abandon_at = 0;
        end else if (pick < 14) begin
          abandon_at = $urandom_range(3, 25);
        end else begin
          row.rad    = 12'($urandom_range(1, 40));
          abandon_at = 1000;
        end
      end
      if (row.op == mcpg_pkg::OP_LOAD || circ_on) begin
        n_items++;
      end
      if (row.op == mcpg_pkg::OP_LOAD) begin
        since_load = 0;
      end else begin
        since_load++;
      end
      send_item(row);
    end

    @(negedge clk);
    in_valid_i = 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mcpg_pkg.sv
hw/rtl/midpoint_circle_pixel_generator.sv
hw/rtl/mcpg_checker.sv
verif/tb_midpoint_circle_pixel_generator.sv
